// ===== sv/wal_pkg.sv =====
// Package for the weekday alarm table: request, response and table entry types,
// action and status codes, and table sizing constants.
// No dependencies.
package wal_pkg;

   localparam int TABLE_DEPTH = 12;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRIES_W   = 4;
   localparam int DAYS_W      = 7;

   localparam logic [4:0] MAX_HOUR   = 5'd23;
   localparam logic [5:0] MAX_MINUTE = 6'd59;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_ADD    = 2'd1,
      ACT_EDIT   = 2'd2,
      ACT_DELETE = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_TIME  = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FIRED     = 3'd4,
      ST_NONE      = 3'd5
   } status_type;

   typedef struct packed {
      action_type          action;
      logic [4:0]          hour;
      logic [5:0]          minute;
      logic [5:0]          second;
      logic [2:0]          weekday;
      logic [15:0]         alarm_id;
      logic [1:0]          difficulty;
      logic                enabled;
      logic [DAYS_W-1:0]   day_mask;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [15:0]            fired_id;
      logic [1:0]             fired_difficulty;
      logic [ENTRIES_W-1:0]   entries_used;
      logic                   last;
   } rsp_type;

   typedef struct packed {
      logic [4:0]          hour;
      logic [5:0]          minute;
      logic [15:0]         id;
      logic [1:0]          diff;
      logic                en;
      logic [DAYS_W-1:0]   days;
   } entry_type;

endpackage

// ===== sv/wal_cell.sv =====
// One cell of the alarm ring: holds a single table entry and loads its
// neighbor's entry when the ring advances. Depends on wal_pkg.
module wal_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  wal_pkg::entry_type  d_in,
   output wal_pkg::entry_type  q_out
);

   wal_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         entry_ff <= d_in;
      end
   end

   assign q_out = entry_ff;

endmodule

// ===== sv/wal_ctrl.sv =====
// Scan controller for the alarm ring: sequences each request over one or two
// ring rotations, edits entries as they pass, and drives the response register.
// Depends on wal_pkg.
module wal_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wal_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wal_pkg::rsp_type    rsp_data,
   input  wal_pkg::entry_type  head,
   output wal_pkg::entry_type  feed,
   output logic                shift_en
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_SCAN = 4'b0010,
      S_MOVE = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type                       state_ff, state_in;
   logic [wal_pkg::IDX_W-1:0]       step_ff, step_in;
   logic [wal_pkg::IDX_W-1:0]       idx_ff, idx_in;
   logic [wal_pkg::CNT_W-1:0]       count_ff, count_in;
   wal_pkg::req_type                req_ff, req_in;
   wal_pkg::entry_type              last_ff, last_in;
   logic                            found_ff, found_in;
   logic                            pend_valid_ff, pend_valid_in;
   logic [15:0]                     pend_id_ff, pend_id_in;
   logic [1:0]                      pend_diff_ff, pend_diff_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   wal_pkg::rsp_type                rsp_ff, rsp_in;

   logic                            out_free;
   logic                            push;
   wal_pkg::rsp_type                push_data;
   logic                            valid_i;
   logic                            last_step;
   logic                            id_hit;
   logic [wal_pkg::DAYS_W:0]        days_ext;
   logic                            day_hit;
   logic                            time_ok;
   logic                            has_room;
   logic                            fire;
   logic                            stall;
   logic [wal_pkg::CNT_W-1:0]       step_cnt;
   wal_pkg::entry_type              new_entry;
   wal_pkg::entry_type              edited;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign step_cnt  = wal_pkg::CNT_W'(step_ff);
   assign valid_i   = step_cnt < count_ff;
   assign last_step = (step_ff == wal_pkg::IDX_W'(wal_pkg::TABLE_DEPTH - 1));
   assign id_hit    = (head.id == req_ff.alarm_id);
   assign days_ext  = {1'b0, head.days};
   assign day_hit   = days_ext[req_ff.weekday];
   assign time_ok   = (req_ff.hour <= wal_pkg::MAX_HOUR) &&
                      (req_ff.minute <= wal_pkg::MAX_MINUTE);
   assign has_room  = count_ff < wal_pkg::CNT_W'(wal_pkg::TABLE_DEPTH);
   assign fire      = (req_ff.action == wal_pkg::ACT_TICK) && (req_ff.second == 6'd0) &&
                      valid_i && head.en && (head.hour == req_ff.hour) &&
                      (head.minute == req_ff.minute) && day_hit;

   always_comb begin
      new_entry.hour   = req_ff.hour;
      new_entry.minute = req_ff.minute;
      new_entry.id     = req_ff.alarm_id;
      new_entry.diff   = req_ff.difficulty;
      new_entry.en     = req_ff.enabled;
      new_entry.days   = req_ff.day_mask;
      edited           = new_entry;
      edited.id        = head.id;
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      req_in        = req_ff;
      last_in       = last_ff;
      found_in      = found_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      pend_diff_in  = pend_diff_ff;
      feed          = head;
      shift_en      = 1'b0;
      stall         = 1'b0;
      push          = 1'b0;
      push_data.status           = wal_pkg::ST_OK;
      push_data.fired_id         = 16'd0;
      push_data.fired_difficulty = 2'd0;
      push_data.entries_used     = wal_pkg::ENTRIES_W'(count_ff);
      push_data.last             = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in        = req_data;
               step_in       = '0;
               found_in      = 1'b0;
               pend_valid_in = 1'b0;
               state_in      = S_SCAN;
            end
         end
         S_SCAN, S_MOVE: begin
            stall = fire && pend_valid_ff && !out_free;
            if (!stall) begin
               shift_en = 1'b1;
               step_in  = last_step ? '0 : step_ff + 1'b1;
               if (fire) begin
                  if (pend_valid_ff) begin
                     push                       = 1'b1;
                     push_data.status           = wal_pkg::ST_FIRED;
                     push_data.fired_id         = pend_id_ff;
                     push_data.fired_difficulty = pend_diff_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = head.id;
                  pend_diff_in  = head.diff;
               end
               unique case (req_ff.action)
                  wal_pkg::ACT_TICK: begin
                  end
                  wal_pkg::ACT_ADD: begin
                     if (time_ok && has_room && (step_cnt == count_ff)) begin
                        feed = new_entry;
                     end
                  end
                  wal_pkg::ACT_EDIT: begin
                     if (valid_i && !found_ff && id_hit) begin
                        feed     = edited;
                        found_in = 1'b1;
                     end
                  end
                  wal_pkg::ACT_DELETE: begin
                     if (state_ff == S_SCAN) begin
                        if (valid_i && !found_ff && id_hit) begin
                           found_in = 1'b1;
                           idx_in   = step_ff;
                        end
                        if (valid_i && (step_cnt == count_ff - 1'b1)) begin
                           last_in = head;
                        end
                     end else if (step_ff == idx_ff) begin
                        feed = last_ff;
                     end
                  end
                  default: begin
                  end
               endcase
               if (last_step) begin
                  if ((state_ff == S_SCAN) && (req_ff.action == wal_pkg::ACT_DELETE) &&
                      found_in) begin
                     state_in = S_MOVE;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               push           = 1'b1;
               push_data.last = 1'b1;
               state_in       = S_IDLE;
               unique case (req_ff.action)
                  wal_pkg::ACT_TICK: begin
                     if (pend_valid_ff) begin
                        push_data.status           = wal_pkg::ST_FIRED;
                        push_data.fired_id         = pend_id_ff;
                        push_data.fired_difficulty = pend_diff_ff;
                     end else begin
                        push_data.status = wal_pkg::ST_NONE;
                     end
                  end
                  wal_pkg::ACT_ADD: begin
                     if (!time_ok) begin
                        push_data.status = wal_pkg::ST_BAD_TIME;
                     end else if (!has_room) begin
                        push_data.status = wal_pkg::ST_FULL;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  wal_pkg::ACT_EDIT: begin
                     if (!found_ff) begin
                        push_data.status = wal_pkg::ST_NOT_FOUND;
                     end
                  end
                  wal_pkg::ACT_DELETE: begin
                     if (found_ff) begin
                        count_in = count_ff - 1'b1;
                     end else begin
                        push_data.status = wal_pkg::ST_NOT_FOUND;
                     end
                  end
                  default: begin
                  end
               endcase
               push_data.entries_used = wal_pkg::ENTRIES_W'(count_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_in       = push_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      idx_ff        <= idx_in;
      req_ff        <= req_in;
      last_ff       <= last_in;
      found_ff      <= found_in;
      pend_valid_ff <= pend_valid_in;
      pend_id_ff    <= pend_id_in;
      pend_diff_ff  <= pend_diff_in;
      rsp_ff        <= rsp_in;
   end

endmodule

// ===== sv/weekday_alarm_table_matcher.sv =====
// Weekday alarm table: a ring of TABLE_DEPTH entry cells that rotates one entry
// per cycle, unless paused as below, past a single compare and edit point in the
// scan controller. Every request takes one full rotation and then a response
// state before the next accept; a delete that finds its id takes a second
// rotation to move the last entry into the freed slot.
// A tick that fires several alarms pauses the rotation while a response waits.
// A new request is taken while the final response of the previous one is still
// waiting. Depends on wal_pkg, wal_cell and wal_ctrl.
module weekday_alarm_table_matcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  wal_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output wal_pkg::rsp_type  rsp_data
);

   wal_pkg::entry_type  cell_q [wal_pkg::TABLE_DEPTH];
   wal_pkg::entry_type  feed;
   logic                shift_en;

   for (genvar i = 0; i < wal_pkg::TABLE_DEPTH; i++) begin : g_cell
      wal_pkg::entry_type cell_d;
      if (i == wal_pkg::TABLE_DEPTH - 1) begin : g_tail
         assign cell_d = feed;
      end else begin : g_mid
         assign cell_d = cell_q[i + 1];
      end
      wal_cell u_cell (
         .clock    (clock),
         .shift_en (shift_en),
         .d_in     (cell_d),
         .q_out    (cell_q[i])
      );
   end

   wal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .head      (cell_q[0]),
      .feed      (feed),
      .shift_en  (shift_en)
   );

endmodule

// ===== tb/sv/tb_weekday_alarm_table_matcher.sv =====
// Testbench for weekday_alarm_table_matcher: directed and random add, edit, delete and
// tick requests with random idling on both channels, checked against a local alarm table.
// Depends on wal_pkg and the weekday_alarm_table_matcher RTL.
module tb_weekday_alarm_table_matcher;
   import wal_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int RANDOM_COUNT   = 235;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type   pending_requests [$];
   rsp_type   expected_responses [$];
   entry_type alarm_table [TABLE_DEPTH];
   int        alarm_count  = 0;
   int        mismatches   = 0;
   int        quiet_cycles = 0;
   logic      quiet_tail   = 1'b0;
   logic      timed_out    = 1'b0;

   int   req_gap, req_calm, rsp_stall, rsp_calm;
   logic req_send, rsp_take;

   logic [4:0]  pool_hour   [6] = '{5'd0, 5'd7, 5'd12, 5'd23, 5'd23, 5'd7};
   logic [5:0]  pool_minute [6] = '{6'd0, 6'd30, 6'd0, 6'd59, 6'd58, 6'd31};
   logic [15:0] pool_id     [8] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h1357, 16'h0001,
                                    16'h8000, 16'h00FF, 16'h1234};

   weekday_alarm_table_matcher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic rsp_type alarm_rsp(status_type st, logic [15:0] id, logic [1:0] diff,
                                         logic fin);
      rsp_type r;
      r.status           = st;
      r.fired_id         = id;
      r.fired_difficulty = diff;
      r.entries_used     = ENTRIES_W'(alarm_count);
      r.last             = fin;
      return r;
   endfunction

   function automatic void store_expected(rsp_type r);
      expected_responses.insert(expected_responses.size(), r);
   endfunction

   task automatic predict_alarm_responses(input req_type rq);
      rsp_type fired [TABLE_DEPTH];
      int      n_fired;
      int      hit;
      n_fired = 0;
      hit     = -1;
      case (rq.action)
         ACT_TICK: begin
            if (rq.second == 6'd0 && rq.weekday < 3'd7)
               for (int i = 0; i < alarm_count; i++)
                  if (alarm_table[i].en && alarm_table[i].hour == rq.hour &&
                      alarm_table[i].minute == rq.minute &&
                      alarm_table[i].days[rq.weekday]) begin
                     fired[n_fired] = alarm_rsp(ST_FIRED, alarm_table[i].id,
                                                alarm_table[i].diff, 1'b0);
                     n_fired++;
                  end
            if (n_fired == 0)
               store_expected(alarm_rsp(ST_NONE, 16'd0, 2'd0, 1'b1));
            else begin
               fired[n_fired-1].last = 1'b1;
               for (int i = 0; i < n_fired; i++)
                  store_expected(fired[i]);
            end
         end
         ACT_ADD: begin
            if (rq.hour > MAX_HOUR || rq.minute > MAX_MINUTE)
               store_expected(alarm_rsp(ST_BAD_TIME, 16'd0, 2'd0, 1'b1));
            else if (alarm_count >= TABLE_DEPTH)
               store_expected(alarm_rsp(ST_FULL, 16'd0, 2'd0, 1'b1));
            else begin
               alarm_table[alarm_count].hour   = rq.hour;
               alarm_table[alarm_count].minute = rq.minute;
               alarm_table[alarm_count].id     = rq.alarm_id;
               alarm_table[alarm_count].diff   = rq.difficulty;
               alarm_table[alarm_count].en     = rq.enabled;
               alarm_table[alarm_count].days   = rq.day_mask;
               alarm_count++;
               store_expected(alarm_rsp(ST_OK, 16'd0, 2'd0, 1'b1));
            end
         end
         default: begin
            for (int i = alarm_count - 1; i >= 0; i--)
               if (alarm_table[i].id == rq.alarm_id)
                  hit = i;
            if (hit < 0)
               store_expected(alarm_rsp(ST_NOT_FOUND, 16'd0, 2'd0, 1'b1));
            else begin
               if (rq.action == ACT_EDIT) begin
                  alarm_table[hit].hour   = rq.hour;
                  alarm_table[hit].minute = rq.minute;
                  alarm_table[hit].diff   = rq.difficulty;
                  alarm_table[hit].en     = rq.enabled;
                  alarm_table[hit].days   = rq.day_mask;
               end else begin
                  alarm_table[hit] = alarm_table[alarm_count-1];
                  alarm_count--;
               end
               store_expected(alarm_rsp(ST_OK, 16'd0, 2'd0, 1'b1));
            end
         end
      endcase
   endtask

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic check_alarm_response(input rsp_type got);
      rsp_type want;
      if (expected_responses.size() == 0) begin
         $error("unexpected response: status %0d fired_id %0d entries_used %0d",
                got.status, got.fired_id, got.entries_used);
         mismatches++;
      end else begin
         want = expected_responses.pop_front();
         check_field("status", want.status, got.status);
         check_field("fired_id", want.fired_id, got.fired_id);
         check_field("fired_difficulty", want.fired_difficulty, got.fired_difficulty);
         check_field("entries_used", want.entries_used, got.entries_used);
         check_field("last", want.last, got.last);
      end
   endtask

   task automatic queue_request(action_type act, logic [4:0] hour, logic [5:0] minute,
                                logic [5:0] second, logic [2:0] weekday, logic [15:0] id,
                                logic [1:0] diff, logic en, logic [6:0] days);
      req_type rq;
      rq.action     = act;
      rq.hour       = hour;
      rq.minute     = minute;
      rq.second     = second;
      rq.weekday    = weekday;
      rq.alarm_id   = id;
      rq.difficulty = diff;
      rq.enabled    = en;
      rq.day_mask   = days;
      pending_requests.insert(pending_requests.size(), rq);
   endtask

   task automatic queue_directed_requests();
      queue_request(ACT_TICK, 5'd0, 6'd0, 6'd0, 3'd0, 16'd0, 2'd0, 1'b0, 7'h00);
      queue_request(ACT_ADD, 5'd24, 6'd0, 6'd0, 3'd0, 16'h4242, 2'd1, 1'b1, 7'h7F);
      queue_request(ACT_ADD, 5'd0, 6'd60, 6'd0, 3'd0, 16'h4242, 2'd1, 1'b1, 7'h7F);
      queue_request(ACT_ADD, 5'd31, 6'd63, 6'd63, 3'd7, 16'hFFFF, 2'd3, 1'b1, 7'h7F);
      // fill the table: six alarms at 23:59 and six at 00:00
      for (int i = 0; i < TABLE_DEPTH; i++)
         queue_request(ACT_ADD, (i < 6) ? 5'd23 : 5'd0, (i < 6) ? 6'd59 : 6'd0,
                       6'd0, 3'd0, (i == 11) ? 16'hFFFF : 16'(i * 16'h1357),
                       2'(i % 4), i != 3, (i % 2 == 0) ? 7'h7F : 7'(1 << (i % 7)));
      queue_request(ACT_ADD, 5'd12, 6'd30, 6'd0, 3'd0, 16'hABCD, 2'd0, 1'b1, 7'h7F);
      queue_request(ACT_TICK, 5'd23, 6'd59, 6'd0, 3'd6, 16'd0, 2'd0, 1'b0, 7'h00);
      queue_request(ACT_TICK, 5'd23, 6'd59, 6'd1, 3'd6, 16'd0, 2'd0, 1'b0, 7'h00);
      queue_request(ACT_TICK, 5'd23, 6'd59, 6'd0, 3'd7, 16'd0, 2'd0, 1'b0, 7'h00);
      queue_request(ACT_EDIT, 5'd31, 6'd63, 6'd0, 3'd0, 16'hFFFF, 2'd3, 1'b1, 7'h7F);
      queue_request(ACT_EDIT, 5'd1, 6'd1, 6'd0, 3'd0, 16'hABCD, 2'd1, 1'b1, 7'h7F);
      queue_request(ACT_DELETE, 5'd0, 6'd0, 6'd0, 3'd0, 16'h0000, 2'd0, 1'b0, 7'h00);
      queue_request(ACT_DELETE, 5'd0, 6'd0, 6'd0, 3'd0, 16'h0000, 2'd0, 1'b0, 7'h00);
      queue_request(ACT_TICK, 5'd0, 6'd0, 6'd0, 3'd0, 16'd0, 2'd0, 1'b0, 7'h00);
   endtask

   // Times and ids come mostly from small pools so that ticks hit stored alarms.
   task automatic queue_random_requests(int count);
      int          pick;
      int          slot;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [15:0] id;
      for (int n = 0; n < count; n++) begin
         pick   = $urandom_range(0, 99);
         slot   = $urandom_range(0, 5);
         hour   = pool_hour[slot];
         minute = pool_minute[slot];
         second = 6'($urandom_range(0, 63));
         id     = pool_id[$urandom_range(0, 7)];
         if ($urandom_range(0, 5) == 0) begin
            hour   = 5'($urandom_range(0, 31));
            minute = 6'($urandom_range(0, 63));
         end
         if ($urandom_range(0, 5) == 0)
            id = 16'($urandom_range(0, 65535));
         if (pick < 35 && $urandom_range(0, 9) < 7)
            second = 6'd0;
         queue_request(pick < 35 ? ACT_TICK : pick < 65 ? ACT_ADD : pick < 80 ? ACT_EDIT
                       : ACT_DELETE, hour, minute, second, 3'($urandom_range(0, 7)), id,
                       2'($urandom_range(0, 3)), $urandom_range(0, 3) != 0,
                       7'($urandom_range(0, 127)));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   = 0;
         req_calm  = 0;
      end else begin
         if (req_valid && req_ready)
            predict_alarm_responses(req_data);
         req_send = req_valid && !req_ready;
         if (req_calm != 0)
            req_calm--;
         if (!req_send) begin
            if (req_gap != 0)
               req_gap--;
            else if (pending_requests.size() != 0) begin
               if (quiet_tail || req_calm != 0 || $urandom_range(0, 4) != 0) begin
                  req_data <= pending_requests.pop_front();
                  req_send = 1'b1;
               end else if ($urandom_range(0, 5) == 0)
                  req_calm = $urandom_range(20, 100);
               else
                  req_gap = $urandom_range(0, 12);
            end
         end
         req_valid  <= req_send;
         quiet_tail <= (pending_requests.size() < 40);
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
         rsp_calm  = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_alarm_response(rsp_data);
         rsp_take = 1'b1;
         if (rsp_calm != 0)
            rsp_calm--;
         if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_take = 1'b0;
         end else if (!quiet_tail && rsp_calm == 0 && $urandom_range(0, 5) == 0) begin
            if ($urandom_range(0, 4) == 0)
               rsp_calm = $urandom_range(20, 100);
            else begin
               rsp_stall = $urandom_range(0, 12);
               rsp_take  = 1'b0;
            end
         end
         rsp_ready <= rsp_take;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      queue_directed_requests();
      queue_random_requests(RANDOM_COUNT);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (!timed_out && (pending_requests.size() != 0 || req_valid ||
                            expected_responses.size() != 0)) begin
         @(posedge clock);
         if (quiet_cycles >= WATCHDOG_LIMIT)
            timed_out = 1'b1;
      end
      if (timed_out)
         $error("watchdog: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      else
         repeat (DRAIN_CYCLES) @(posedge clock);
      if (!timed_out && expected_responses.size() != 0)
         $error("missing responses: expected %0d, got %0d", expected_responses.size(), 0);
      if (!timed_out && mismatches == 0 && expected_responses.size() == 0)
         $display("weekday_alarm_table_matcher test passed");
      else
         $display("weekday_alarm_table_matcher test failed");
      $finish;
   end

endmodule
